>>> rtl/scfr_pkg.sv
// Package: types and constants for the second-chance frame replacer.
package scfr_pkg;
  localparam int FRAMES = 16;
  localparam int ADDR_BITS = 48;
  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_LOOKUP = 3'd1;
  localparam logic [2:0] REQ_MARK   = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_EVICT  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [47:0] page_addr;
    logic        ref_value;
    logic        mod_value;
  } scfr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic        entry_ref;
    logic        entry_mod;
    logic [47:0] victim_addr;
    logic        victim_valid;
    logic        victim_dirty;
    logic [4:0]  frames_used;
  } scfr_out_t;
endpackage

>>> rtl/second_chance_frame_replacer.sv
// Top level: second-chance frame replacer with sequenced search, walk and shift.
// Channels: in_valid/in_stall/in_data take one request transaction; out_valid/
// out_stall/out_data return exactly one result transaction per request.
// A request is taken only when idle; the block is busy until its result is
// placed in the output register. A new request may be taken while that result
// waits under out_stall, but the next result is not produced until it leaves.
// Per request: insert goes straight to the result; lookup/mark search from entry
// 0 to the match or the tail; remove then shifts each entry from the match to the tail; evict
// walks one entry per cycle (clearing at most 3*FRAMES+1 bits), takes the victim,
// then shifts the tail one entry per cycle.
// The single compare/shift datapath steps over the table one entry a cycle.
// Reset clears the count, the reference and modified bits and the output
// valid; page addresses are unknown until written and never read before.
module second_chance_frame_replacer
  import scfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  scfr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output scfr_out_t out_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_SHFT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam int STEP_W = $clog2(3 * FRAMES + 2);
  localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(3 * FRAMES + 1);

  logic [ADDR_BITS-1:0] page_r [FRAMES];
  logic [FRAMES-1:0] ref_r, mod_r;
  logic [CNT_W-1:0] cnt_r;
  logic [2:0] state_r;
  scfr_in_t req_r;
  logic [IDX_W-1:0] idx_r;
  logic [STEP_W-1:0] step_r;
  scfr_out_t res_r, out_r;
  scfr_out_t res_out;
  logic out_valid_r;

  logic [CNT_W-1:0] idx_ext, idx_inc;
  logic last;
  assign idx_ext = CNT_W'(idx_r);
  assign idx_inc = idx_ext + 1'b1;
  assign last = (idx_inc >= cnt_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  function automatic scfr_out_t result_of(logic [1:0] st, logic fnd, logic eref,
                                          logic emod, logic [ADDR_BITS-1:0] vaddr,
                                          logic vvalid, logic vdirty);
    scfr_out_t r;
    r = '0;
    r.status = st;
    r.found = fnd;
    r.entry_ref = eref;
    r.entry_mod = emod;
    r.victim_addr = 48'(vaddr);
    r.victim_valid = vvalid;
    r.victim_dirty = vdirty;
    return r;
  endfunction

  always_comb begin
    res_out = res_r;
    res_out.frames_used = 5'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SHFT && !last) begin
      page_r[idx_r] <= page_r[IDX_W'(idx_inc)];
    end else if (state_r == S_IDLE && in_valid && in_data.req_type == REQ_INSERT &&
                 cnt_r < CNT_W'(FRAMES)) begin
      page_r[IDX_W'(cnt_r)] <= in_data.page_addr[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ref_r <= '0;
      mod_r <= '0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      step_r <= '0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            idx_r <= '0;
            step_r <= '0;
            case (in_data.req_type)
              REQ_INSERT: begin
                state_r <= S_DONE;
                if (cnt_r >= CNT_W'(FRAMES)) begin
                  res_r <= result_of(ST_FULL, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
                end else begin
                  res_r <= result_of(ST_OK, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
                  ref_r[IDX_W'(cnt_r)] <= 1'b0;
                  mod_r[IDX_W'(cnt_r)] <= 1'b0;
                  cnt_r <= cnt_r + 1'b1;
                end
              end
              REQ_LOOKUP, REQ_MARK, REQ_REMOVE: begin
                if (cnt_r == '0) begin
                  res_r <= result_of(ST_EMPTY, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_SRCH;
                end
              end
              REQ_EVICT: begin
                if (cnt_r == '0) begin
                  res_r <= result_of(ST_EMPTY, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
                  state_r <= S_DONE;
                end else if (cnt_r > CNT_W'(1) && ref_r[0]) begin
                  state_r <= S_WALK;
                end else begin
                  res_r <= result_of(ST_OK, 1'b0, 1'b0, 1'b0, page_r[0], 1'b1, mod_r[0]);
                  state_r <= S_SHFT;
                end
              end
              default: begin
                res_r <= '0;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (page_r[idx_r] == req_r.page_addr[ADDR_BITS-1:0]) begin
            res_r <= result_of(ST_OK, 1'b1,
                               (req_r.req_type == REQ_LOOKUP) ? ref_r[idx_r] : 1'b0,
                               (req_r.req_type == REQ_LOOKUP) ? mod_r[idx_r] : 1'b0,
                               '0, 1'b0, 1'b0);
            state_r <= (req_r.req_type == REQ_REMOVE) ? S_SHFT : S_DONE;
            if (req_r.req_type == REQ_MARK) begin
              ref_r[idx_r] <= req_r.ref_value;
              mod_r[idx_r] <= req_r.mod_value;
            end
          end else if (last) begin
            res_r <= result_of(ST_NOTFOUND, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_WALK: begin
          if ((ref_r[idx_r] || mod_r[idx_r]) && step_r < STEP_CAP) begin
            if (ref_r[idx_r]) ref_r[idx_r] <= 1'b0;
            else mod_r[idx_r] <= 1'b0;
            idx_r <= last ? '0 : idx_r + 1'b1;
            step_r <= step_r + 1'b1;
          end else begin
            res_r <= result_of(ST_OK, 1'b0, 1'b0, 1'b0, page_r[idx_r], 1'b1,
                               mod_r[idx_r]);
            state_r <= S_SHFT;
          end
        end
        S_SHFT: begin
          if (last) begin
            cnt_r <= cnt_r - 1'b1;
            state_r <= S_DONE;
          end else begin
            ref_r[idx_r] <= ref_r[IDX_W'(idx_inc)];
            mod_r[idx_r] <= mod_r[IDX_W'(idx_inc)];
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r <= res_out;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAMES)) else $error("count over table size");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result lost under stall");
  a_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.victim_valid) |-> (out_data.status == ST_OK))
    else $error("victim with bad status");
endmodule

>>> dv/second_chance_frame_replacer_test.sv
// Testbench: drives requests into the frame replacer and checks every result against a predictor.
`timescale 1ns / 1ps
module second_chance_frame_replacer_test;
  import scfr_pkg::*;

  class frame_table_scoreboard;
    logic [47:0] page_q[$];
    bit          ref_q[$];
    bit          mod_q[$];
    scfr_out_t   pending_q[$];
    int          errors;

    function int locate_page(logic [47:0] addr);
      foreach (page_q[i]) if (page_q[i] == addr) return i;
      return -1;
    endfunction

    function void note_request(scfr_in_t req);
      scfr_out_t r;
      int pos;
      int cur;
      int steps;
      r = '0;
      case (req.req_type)
        REQ_INSERT: begin
          if (page_q.size() >= FRAMES) r.status = ST_FULL;
          else begin
            page_q.push_back(req.page_addr);
            ref_q.push_back(1'b0);
            mod_q.push_back(1'b0);
          end
        end
        REQ_LOOKUP, REQ_MARK, REQ_REMOVE: begin
          if (page_q.size() == 0) r.status = ST_EMPTY;
          else begin
            pos = locate_page(req.page_addr);
            if (pos < 0) r.status = ST_NOTFOUND;
            else begin
              r.found = 1'b1;
              if (req.req_type == REQ_LOOKUP) begin
                r.entry_ref = ref_q[pos];
                r.entry_mod = mod_q[pos];
              end else if (req.req_type == REQ_MARK) begin
                ref_q[pos] = req.ref_value;
                mod_q[pos] = req.mod_value;
              end else begin
                page_q.delete(pos);
                ref_q.delete(pos);
                mod_q.delete(pos);
              end
            end
          end
        end
        REQ_EVICT: begin
          if (page_q.size() == 0) r.status = ST_EMPTY;
          else begin
            cur = 0;
            if (page_q.size() > 1 && ref_q[0]) begin
              steps = 0;
              while ((ref_q[cur] || mod_q[cur]) && steps < 3 * FRAMES + 1) begin
                if (ref_q[cur]) ref_q[cur] = 1'b0;
                else mod_q[cur] = 1'b0;
                cur = (cur + 1 >= page_q.size()) ? 0 : cur + 1;
                steps++;
              end
            end
            r.victim_addr = page_q[cur];
            r.victim_dirty = mod_q[cur];
            r.victim_valid = 1'b1;
            page_q.delete(cur);
            ref_q.delete(cur);
            mod_q.delete(cur);
          end
        end
        default: ;
      endcase
      r.frames_used = 5'(page_q.size());
      pending_q.push_back(r);
    endfunction

    function void check_result(scfr_out_t got);
      scfr_out_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status || got.found !== exp.found ||
          got.entry_ref !== exp.entry_ref || got.entry_mod !== exp.entry_mod ||
          got.victim_addr !== exp.victim_addr ||
          got.victim_valid !== exp.victim_valid ||
          got.victim_dirty !== exp.victim_dirty ||
          got.frames_used !== exp.frames_used) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  scfr_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  scfr_out_t out_data;

  frame_table_scoreboard sb;
  bit   calm;
  logic [47:0] used_pages[$];

  second_chance_frame_replacer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  task automatic send_request(logic [2:0] kind, logic [47:0] addr, bit rv, bit mv);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: kind, page_addr: addr, ref_value: rv, mod_value: mv};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == REQ_INSERT) used_pages.push_back(addr);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [47:0] pick_page();
    if (used_pages.size() != 0 && $urandom_range(99) < 80)
      return used_pages[$urandom_range(used_pages.size() - 1)];
    return 48'({$urandom, $urandom});
  endfunction

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [2:0] kind;
    int roll;
    sb = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table cases
    send_request(REQ_EVICT, 48'h0, 1'b0, 1'b0);
    send_request(REQ_LOOKUP, 48'h0, 1'b0, 1'b0);
    send_request(REQ_MARK, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(REQ_REMOVE, 48'h1, 1'b0, 1'b0);
    send_request(3'd7, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(3'd5, 48'h0, 1'b0, 1'b0);
    // single entry with ref set: taken at once
    send_request(REQ_INSERT, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_request(REQ_MARK, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(REQ_EVICT, 48'h0, 1'b0, 1'b0);
    // fill to full with duplicates, then overflow
    for (int i = 0; i < FRAMES; i++)
      send_request(REQ_INSERT, (i == 3) ? 48'h0 : 48'h1000 * (i % 8), 1'b0, 1'b0);
    send_request(REQ_INSERT, 48'hABCD, 1'b0, 1'b0);
    // set both bits on the first copy of each page; the evict walk stops at entry 3
    for (int i = 0; i < 8; i++) send_request(REQ_MARK, 48'h1000 * i, 1'b1, 1'b1);
    send_request(REQ_LOOKUP, 48'h1000, 1'b0, 1'b0);
    send_request(REQ_LOOKUP, 48'h5555, 1'b0, 1'b0);
    send_request(REQ_EVICT, 48'h0, 1'b0, 1'b0);
    send_request(REQ_REMOVE, 48'h2000, 1'b0, 1'b0);
    wait_drained();

    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 230);
      if (n == 300) wait_drained();
      roll = $urandom_range(99);
      if (roll < 30) kind = REQ_INSERT;
      else if (roll < 45) kind = REQ_LOOKUP;
      else if (roll < 70) kind = REQ_MARK;
      else if (roll < 80) kind = REQ_REMOVE;
      else if (roll < 97) kind = REQ_EVICT;
      else kind = 3'($urandom_range(5, 7));
      send_request(kind, pick_page(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    calm = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
